FILE: rtl/lsbp_pkg.sv
// ----------------------------------------------------------------------------
// lsbp_pkg
// Shared types and constants for the LSB-first bit packer.
// ----------------------------------------------------------------------------
package lsbp_pkg;

  // Fixed field widths
  localparam int CMD_W   = 1;
  localparam int LEN_W   = 6;
  localparam int VALUE_W = 32;
  localparam int BYTE_W  = 8;
  localparam int TOTAL_W = 32;

  // Item commands
  localparam logic [CMD_W-1:0] CMD_APPEND = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 1'b1;

  // Controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // input item taken this cycle
    logic advance;  // current result taken this cycle
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;     // current result is the final one of the item
  } dp_status_t;

endpackage

FILE: rtl/lsbp_ctrl.sv
// ----------------------------------------------------------------------------
// lsbp_ctrl
// Handshake controller: takes one item, then hands out its results.
// ----------------------------------------------------------------------------
module lsbp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lsbp_pkg::dp_status_t status,
  output lsbp_pkg::dp_cmd_t   cmd_o
);
  import lsbp_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready && status.last) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.advance = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd_o.load = in_valid;
      end
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd_o.advance = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Never both sides open at once
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("lsbp_ctrl: input and output open together");

  // A taken item is followed by a result
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("lsbp_ctrl: no result after item");

  // Final result taken returns to idle
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && status.last) |=> in_ready)
    else $error("lsbp_ctrl: not idle after final result");

endmodule

FILE: rtl/lsbp_datapath.sv
// ----------------------------------------------------------------------------
// lsbp_datapath
// Bit accumulator, bit count and running total; at most one byte out per step.
// ----------------------------------------------------------------------------
module lsbp_datapath #(
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lsbp_pkg::dp_cmd_t             cmd_i,
  output lsbp_pkg::dp_status_t          status,
  input  logic [lsbp_pkg::CMD_W-1:0]    cmd,
  input  logic [lsbp_pkg::LEN_W-1:0]    field_length,
  input  logic [lsbp_pkg::VALUE_W-1:0]  field_value,
  output logic [lsbp_pkg::BYTE_W-1:0]   out_byte,
  output logic                          byte_valid,
  output logic [lsbp_pkg::TOTAL_W-1:0]  total_bits,
  output logic                          last
);
  import lsbp_pkg::*;

  // Accumulator holds up to seven pending bits plus one full field
  localparam int ACC_W = MAX_FIELD_BITS + BYTE_W;
  localparam int CNT_W = $clog2(MAX_FIELD_BITS + BYTE_W);
  localparam int HI_W  = CNT_W - 3;
  localparam int EXT_W = (ACC_W > VALUE_W) ? ACC_W : VALUE_W;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FIELD_BITS);

  // Between items: acc holds the pending bits (low end), n the count (< 8)
  logic [ACC_W-1:0]   acc;
  logic [CNT_W-1:0]   n;
  logic [TOTAL_W-1:0] bit_total;
  logic               flush_q;

  logic [LEN_W-1:0]   len_sat;
  logic [EXT_W-1:0]   val_ext;
  logic [ACC_W-1:0]   masked;
  logic [HI_W-1:0]    n_hi;
  logic               byte_ok;

  // Saturate length and keep only the low len_sat bits of the value
  assign len_sat = (field_length > MAX_LEN) ? MAX_LEN : field_length;
  assign val_ext = EXT_W'(field_value);

  always_comb begin
    for (int i = 0; i < ACC_W; i++) begin
      masked[i] = val_ext[i] & (i < int'(len_sat));
    end
  end

  // Result fields
  assign n_hi       = n[CNT_W-1:3];
  assign byte_ok    = flush_q ? (n != '0) : (n_hi != '0);
  assign byte_valid = byte_ok;
  assign out_byte   = byte_ok ? acc[BYTE_W-1:0] : '0;
  assign total_bits = bit_total;
  assign last       = flush_q || (n_hi <= HI_W'(1));
  assign status.last = last;

  // Accumulator, count and total
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      n         <= '0;
      bit_total <= '0;
      flush_q   <= 1'b0;
    end else if (cmd_i.load) begin
      if (cmd == CMD_FLUSH) begin
        flush_q <= 1'b1;
      end else begin
        flush_q   <= 1'b0;
        acc       <= ACC_W'(acc[6:0]) | (masked << n[2:0]);
        n         <= CNT_W'(n[2:0]) + CNT_W'(len_sat);
        bit_total <= bit_total + TOTAL_W'(len_sat);
      end
    end else if (cmd_i.advance) begin
      if (flush_q) begin
        acc       <= '0;
        n         <= '0;
        bit_total <= '0;
      end else if (byte_ok) begin
        acc <= acc >> BYTE_W;
        n   <= n - CNT_W'(BYTE_W);
      end
    end
  end

  // A non-final result always carries a byte
  assert property (@(posedge clk) disable iff (rst)
    (cmd_i.advance && !last) |-> byte_ok)
    else $error("lsbp_datapath: empty byte before final result");

  // After a final append result fewer than eight bits stay pending
  assert property (@(posedge clk) disable iff (rst)
    (cmd_i.advance && last) |=> (n_hi == '0))
    else $error("lsbp_datapath: pending count out of range");

  // Flush clears the pending bits, the bit count and the running total
  assert property (@(posedge clk) disable iff (rst)
    (cmd_i.advance && flush_q) |=> (n == '0 && bit_total == '0))
    else $error("lsbp_datapath: flush did not clear");

endmodule

FILE: rtl/lsb_first_bit_packer_top.sv
// The first result of an item is offered in the cycle after the item is taken.
// Flow: an item yields k results (1 to 4 at the default field size, up to 8
//   at the largest); the output register shifts out one byte per cycle while
//   out_ready is high, and the next item is taken only after the final result.
// Reset: clears the pending bits, the bit count and the running total.
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_top
// Packs variable-length fields into an LSB-first byte stream.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_top #(
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lsbp_pkg::CMD_W-1:0]    cmd,
  input  logic [lsbp_pkg::LEN_W-1:0]    field_length,
  input  logic [lsbp_pkg::VALUE_W-1:0]  field_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lsbp_pkg::BYTE_W-1:0]   out_byte,
  output logic                          byte_valid,
  output logic [lsbp_pkg::TOTAL_W-1:0]  total_bits,
  output logic                          last
);
  import lsbp_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Controller
  lsbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (dp_status),
    .cmd_o     (dp_cmd)
  );

  // Datapath
  lsbp_datapath #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd_i        (dp_cmd),
    .status       (dp_status),
    .cmd          (cmd),
    .field_length (field_length),
    .field_value  (field_value),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .total_bits   (total_bits),
    .last         (last)
  );

endmodule
